[hdl/double_column_buffer_deadtime_defines.svh]
// Assertion macros used by the top-level RTL file of the double-column buffer block.
`ifndef DOUBLE_COLUMN_BUFFER_DEADTIME_DEFINES_SVH
`define DOUBLE_COLUMN_BUFFER_DEADTIME_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define DCBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define DCBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/dcbd_pkg.sv]
package dcbd_pkg;

    localparam int TIME_W  = 31;
    localparam int ENTRY_W = TIME_W + 1;
    localparam int DRAIN_W = 8;

    localparam logic [5:0]         COL_LAST    = 6'd51;
    localparam logic [6:0]         ROW_LAST    = 7'd79;
    localparam logic [DRAIN_W-1:0] DRAIN_RESET = 8'd6;

    localparam logic [1:0] ST_RANGE   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_MASKED  = 2'd2;
    localparam logic [1:0] ST_KEPT    = 2'd3;

    typedef struct packed {
        logic       found;
        logic [1:0] taken;
    } t_check;

endpackage

[hdl/dcbd_intf.sv]
interface dcbd_hit_if;
    logic        valid;
    logic        ready;
    logic [4:0]  channel;
    logic [1:0]  chip;
    logic [5:0]  column;
    logic [6:0]  row;
    logic [30:0] event_count;
    logic        pixel_masked;

    modport source (output valid, channel, chip, column, row, event_count, pixel_masked,
                    input ready);
    modport sink (input valid, channel, chip, column, row, event_count, pixel_masked,
                  output ready);
endinterface

interface dcbd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] slot_taken;

    modport source (output valid, status, slot_taken, input ready);
    modport sink (input valid, status, slot_taken, output ready);
endinterface

[hdl/dcbd_ram.sv]
module dcbd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/dcbd_slot_check.sv]
module dcbd_slot_check #(
    parameter int SLOTS = 3
) (
    input  logic [SLOTS*dcbd_pkg::ENTRY_W-1:0] i_word,
    input  logic [dcbd_pkg::TIME_W-1:0]        i_now,
    input  logic [dcbd_pkg::DRAIN_W-1:0]       i_drain,
    output dcbd_pkg::t_check                   o_check,
    output logic [SLOTS*dcbd_pkg::ENTRY_W-1:0] o_word
);

    import dcbd_pkg::*;

    logic [SLOTS-1:0] free;

    always_comb begin
        logic        vld;
        logic [TIME_W-1:0] stamp;
        logic signed [TIME_W+1:0] age;
        for (int s = 0; s < SLOTS; s++) begin
            vld   = i_word[s*ENTRY_W + TIME_W];
            stamp = i_word[s*ENTRY_W +: TIME_W];
            age   = $signed({2'b00, i_now}) - $signed({2'b00, stamp});
            free[s] = !vld || (age > $signed({{(TIME_W+2-DRAIN_W){1'b0}}, i_drain}));
        end
    end

    always_comb begin
        int sel;
        o_check = '0;
        o_word  = i_word;
        sel     = SLOTS;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (free[s]) begin
                o_check.found = 1'b1;
                o_check.taken = 2'(s);
                sel           = s;
            end
        end
        for (int s = 0; s < SLOTS; s++) begin
            if (s == sel) begin
                o_word[s*ENTRY_W +: ENTRY_W] = {1'b1, i_now};
            end
        end
    end

endmodule

[hdl/double_column_buffer_deadtime.sv]
// Double-column buffer dead time. Each hit is answered by one result: rejected
// when it lies outside the pixel array, blocked when every buffer slot of its
// double column is still draining, otherwise the index of the first free slot
// and whether the pixel is masked. All slots of one double column share one
// word of a synchronous RAM, so a hit costs one read and, when a slot is taken,
// one write back: the block takes no new hit until the last one is finished,
// and it registers a result only once the output register is empty or being
// read. After reset the RAM is cleared one word per cycle, over all
// NUM_CHANNELS * NUM_CHIPS * NUM_DCOLS words (1872 at the default values);
// no hit is accepted during that pass, but the drain setting can be written.
`include "double_column_buffer_deadtime_defines.svh"

module double_column_buffer_deadtime #(
    parameter int NUM_CHANNELS = 24,
    parameter int NUM_CHIPS    = 3,
    parameter int NUM_DCOLS    = 26,
    parameter int SLOTS        = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dcbd_hit_if.sink                     i_hit,
    dcbd_res_if.source                   o_res,
    input  logic                         i_cfg_we,
    input  logic [dcbd_pkg::DRAIN_W-1:0] i_cfg_data
);

    import dcbd_pkg::*;

    localparam int DEPTH  = NUM_CHANNELS * NUM_CHIPS * NUM_DCOLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = SLOTS * ENTRY_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_addr;
    logic [TIME_W-1:0]   r_now;
    logic                r_masked;
    logic                r_in_range;
    logic [DRAIN_W-1:0]  r_drain;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [1:0]          r_taken;

    logic                accept;
    logic                in_range;
    logic [ADDR_W-1:0]   hit_addr;
    logic                load;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   upd_word;
    t_check              check;

    assign i_hit.ready = (r_state == S_IDLE);
    assign accept      = i_hit.valid && i_hit.ready;

    assign in_range = (int'(i_hit.channel) < NUM_CHANNELS) &&
                      (int'(i_hit.chip) < NUM_CHIPS) &&
                      (i_hit.column <= COL_LAST) &&
                      (i_hit.row <= ROW_LAST) &&
                      (int'(i_hit.column[5:1]) < NUM_DCOLS);

    assign hit_addr = ADDR_W'((int'(i_hit.channel) * NUM_CHIPS + int'(i_hit.chip))
                              * NUM_DCOLS + int'(i_hit.column[5:1]));

    assign load = (r_state == S_LOOK) && (!r_out_valid || o_res.ready);

    assign ram_we    = (r_state == S_CLEAR) || (load && r_in_range && check.found);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : upd_word;

    dcbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept),
        .i_raddr(hit_addr),
        .o_rdata(ram_rdata)
    );

    dcbd_slot_check #(
        .SLOTS(SLOTS)
    ) u_check (
        .i_word (ram_rdata),
        .i_now  (r_now),
        .i_drain(r_drain),
        .o_check(check),
        .o_word (upd_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_drain     <= DRAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_drain <= i_cfg_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_addr     <= hit_addr;
            r_now      <= i_hit.event_count;
            r_masked   <= i_hit.pixel_masked;
            r_in_range <= in_range;
        end
        if (load) begin
            priority if (!r_in_range) begin
                r_status <= ST_RANGE;
                r_taken  <= 2'd0;
            end else if (!check.found) begin
                r_status <= ST_BLOCKED;
                r_taken  <= 2'd0;
            end else begin
                r_status <= r_masked ? ST_MASKED : ST_KEPT;
                r_taken  <= check.taken;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.slot_taken = r_taken;

    `DCBD_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !i_hit.ready, "hit accepted during clearing pass")
    `DCBD_ASSERT(a_accept_to_look, i_clk, i_rst_n, accept |=> (r_state == S_LOOK), "accepted hit did not reach lookup")
    `DCBD_ASSERT(a_result_after_look, i_clk, i_rst_n, load |=> o_res.valid, "finished hit produced no result")
    `DCBD_ASSERT_ALWAYS(a_no_write_in_idle, i_clk, (r_state == S_IDLE) |-> !ram_we, "memory written while idle")

endmodule

[tb/dcbd_deadtime_checker.sv]
module dcbd_deadtime_checker #(
    parameter int NUM_CHANNELS = 24,
    parameter int NUM_CHIPS    = 3,
    parameter int NUM_DCOLS    = 26,
    parameter int SLOTS        = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dcbd_hit_if                          i_hit,
    dcbd_res_if                          i_res,
    input  logic                         i_cfg_we,
    input  logic [dcbd_pkg::DRAIN_W-1:0] i_cfg_data,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    import dcbd_pkg::*;

    localparam int SLOT_COUNT = NUM_CHANNELS * NUM_CHIPS * NUM_DCOLS * SLOTS;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] slot_taken;
    } t_outcome;

    logic [TIME_W-1:0]  slot_time [SLOT_COUNT];
    bit                 slot_used [SLOT_COUNT];
    logic [DRAIN_W-1:0] drain;
    t_outcome           outcome_q [$];
    int                 mismatches = 0;

    function automatic t_outcome predict_outcome(input logic [4:0] ch, input logic [1:0] cp,
                                                 input logic [5:0] col, input logic [6:0] row,
                                                 input logic [TIME_W-1:0] now,
                                                 input logic masked);
        t_outcome r;
        int       dc;
        int       base;
        int       k;
        bit       free;
        r.status     = ST_BLOCKED;
        r.slot_taken = 2'd0;
        dc = int'(col) / 2;
        if (int'(ch) >= NUM_CHANNELS || int'(cp) >= NUM_CHIPS || col > COL_LAST ||
            row > ROW_LAST || dc >= NUM_DCOLS) begin
            r.status = ST_RANGE;
            return r;
        end
        base = ((int'(ch) * NUM_CHIPS + int'(cp)) * NUM_DCOLS + dc) * SLOTS;
        for (int s = 0; s < SLOTS; s++) begin
            k = base + s;
            if (!slot_used[k]) begin
                free = 1'b1;
            end else begin
                free = (longint'(now) - longint'(slot_time[k])) > longint'(drain);
            end
            if (free) begin
                slot_used[k] = 1'b1;
                slot_time[k] = now;
                r.status     = masked ? ST_MASKED : ST_KEPT;
                r.slot_taken = 2'(s);
                return r;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_outcome want;
        if (!i_rst_n) begin
            slot_used = '{default: 1'b0};
            drain = DRAIN_RESET;
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                drain = i_cfg_data;
            end
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no hit waiting: status %0d, slot_taken %0d",
                           i_res.status, i_res.slot_taken);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== i_res.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        mismatches++;
                    end
                    if (want.slot_taken !== i_res.slot_taken) begin
                        $error("slot_taken: expected %0d, got %0d", want.slot_taken,
                               i_res.slot_taken);
                        mismatches++;
                    end
                end
            end
            if (i_hit.valid && i_hit.ready) begin
                outcome_q = {outcome_q, predict_outcome(i_hit.channel, i_hit.chip,
                                                        i_hit.column, i_hit.row,
                                                        i_hit.event_count,
                                                        i_hit.pixel_masked)};
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= outcome_q.size();
    end

endmodule

[tb/tb_double_column_buffer_deadtime.sv]
module tb_double_column_buffer_deadtime;
    import dcbd_pkg::*;

    localparam int NUM_CHANNELS   = 24;
    localparam int NUM_CHIPS      = 3;
    localparam int NUM_DCOLS      = 26;
    localparam int SLOTS          = 3;
    localparam int STALL_LIMIT    = 20000;
    localparam int PHASES         = 7;
    localparam int HITS_PER_PHASE = 190;
    localparam int HOT_SPOTS      = 4;
    localparam longint EV_MAX     = 64'h7FFF_FFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [DRAIN_W-1:0] cfg_data;
    int                 mismatches;
    int                 outstanding;
    int                 stall_cycles = 0;
    int                 hits_sent = 0;
    bit                 quiet = 1'b0;
    logic [DRAIN_W-1:0] drain_now;
    longint             next_ev;
    logic [4:0]         hot_ch [HOT_SPOTS];
    logic [1:0]         hot_cp [HOT_SPOTS];
    int                 hot_dc [HOT_SPOTS];

    dcbd_hit_if hit_bus ();
    dcbd_res_if res_bus ();

    double_column_buffer_deadtime #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .NUM_CHIPS   (NUM_CHIPS),
        .NUM_DCOLS   (NUM_DCOLS),
        .SLOTS       (SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hit     (hit_bus),
        .o_res     (res_bus),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    dcbd_deadtime_checker #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .NUM_CHIPS   (NUM_CHIPS),
        .NUM_DCOLS   (NUM_DCOLS),
        .SLOTS       (SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hit        (hit_bus),
        .i_res        (res_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (hit_bus.valid && hit_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_hit(input logic [4:0] ch, input logic [1:0] cp, input logic [5:0] col,
                            input logic [6:0] row, input logic [TIME_W-1:0] ev,
                            input logic msk);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            hit_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hit_bus.valid        <= 1'b1;
        hit_bus.channel      <= ch;
        hit_bus.chip         <= cp;
        hit_bus.column       <= col;
        hit_bus.row          <= row;
        hit_bus.event_count  <= ev;
        hit_bus.pixel_masked <= msk;
        do @(posedge i_clk); while (!(hit_bus.valid && hit_bus.ready));
    endtask

    task automatic wait_idle();
        hit_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_drain(input logic [DRAIN_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        drain_now = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_hit();
        logic [4:0] ch;
        logic [1:0] cp;
        logic [5:0] col;
        logic [6:0] row;
        int         dc;
        int         h;
        int         pick;
        int         r;
        longint     span;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            h  = $urandom_range(0, HOT_SPOTS - 1);
            ch = hot_ch[h];
            cp = hot_cp[h];
            dc = hot_dc[h];
        end else begin
            ch = 5'($urandom_range(0, NUM_CHANNELS - 1));
            cp = 2'($urandom_range(0, NUM_CHIPS - 1));
            dc = $urandom_range(0, NUM_DCOLS - 1);
        end
        col = 6'(dc * 2 + $urandom_range(0, 1));
        row = 7'($urandom_range(0, int'(ROW_LAST)));
        if (pick >= 90) begin
            case ($urandom_range(0, 4))
                0: ch = 5'($urandom_range(NUM_CHANNELS, 31));
                1: cp = 2'($urandom_range(NUM_CHIPS, 3));
                2: col = 6'($urandom_range(int'(COL_LAST) + 1, 63));
                3: row = 7'($urandom_range(int'(ROW_LAST) + 1, 127));
                default: {ch, cp, col, row} = 20'($urandom);
            endcase
        end
        r    = $urandom_range(0, 99);
        span = longint'(drain_now) + 2;
        if (r < 50) begin
            next_ev += $urandom_range(0, 2);
        end else if (r < 80) begin
            next_ev += $urandom_range(0, 32'(span));
        end else if (r < 88) begin
            next_ev += $urandom_range(0, 1 << 20);
        end else if (r < 95) begin
            next_ev -= $urandom_range(0, 32'(span + 2));
        end else begin
            next_ev = $urandom_range(0, 32'h7FFF_FFFF);
        end
        if (next_ev < 0) begin
            next_ev = 0;
        end else if (next_ev > EV_MAX) begin
            next_ev = EV_MAX;
        end
        send_hit(ch, cp, col, row, 31'(next_ev), 1'($urandom));
        hits_sent++;
        if (hits_sent % 64 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
        end
    endtask

    initial begin : result_sink
        int gap;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
        end
    end

    initial begin
        hit_bus.valid        <= 1'b0;
        hit_bus.channel      <= '0;
        hit_bus.chip         <= '0;
        hit_bus.column       <= '0;
        hit_bus.row          <= '0;
        hit_bus.event_count  <= '0;
        hit_bus.pixel_masked <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_data             <= DRAIN_RESET;
        i_rst_n              <= 1'b0;
        drain_now = DRAIN_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: write_drain(8'd0);
                    2: write_drain(8'd255);
                    3: write_drain(8'($urandom_range(2, 20)));
                    4: write_drain(8'd1);
                    5: write_drain(8'($urandom_range(0, 255)));
                    default: write_drain(8'd7);
                endcase
            end
            if (phase == 0) begin
                // Fill one double column, then let its first slot drain.
                send_hit(5'd0, 2'd0, 6'd0, 7'd0, 31'd0, 1'b0);
                send_hit(5'd0, 2'd0, 6'd1, 7'd5, 31'd0, 1'b0);
                send_hit(5'd0, 2'd0, 6'd0, 7'd9, 31'd0, 1'b1);
                send_hit(5'd0, 2'd0, 6'd1, 7'd0, 31'd0, 1'b0);
                send_hit(5'd0, 2'd0, 6'd0, 7'd1, 31'd6, 1'b0);
                send_hit(5'd0, 2'd0, 6'd0, 7'd2, 31'd7, 1'b0);
                send_hit(5'd23, 2'd2, 6'd51, 7'd79, 31'd7, 1'b1);
                // Hits outside the pixel array.
                send_hit(5'd24, 2'd0, 6'd0, 7'd0, 31'd7, 1'b0);
                send_hit(5'd0, 2'd3, 6'd0, 7'd0, 31'd7, 1'b0);
                send_hit(5'd0, 2'd0, 6'd52, 7'd0, 31'd7, 1'b0);
                send_hit(5'd0, 2'd0, 6'd0, 7'd80, 31'd7, 1'b1);
                send_hit(5'd31, 2'd3, 6'd63, 7'd127, 31'h7FFF_FFFF, 1'b1);
                // An event count that goes backward against a used slot.
                send_hit(5'd23, 2'd2, 6'd50, 7'd40, 31'd3, 1'b0);
                send_hit(5'd23, 2'd2, 6'd50, 7'd41, 31'd3, 1'b0);
                send_hit(5'd23, 2'd2, 6'd51, 7'd42, 31'd3, 1'b0);
                // The largest event count, then a drop to zero.
                send_hit(5'd5, 2'd1, 6'd20, 7'd64, 31'h7FFF_FFFF, 1'b0);
                send_hit(5'd5, 2'd1, 6'd21, 7'd64, 31'h7FFF_FFFF, 1'b1);
                send_hit(5'd5, 2'd1, 6'd20, 7'd33, 31'd0, 1'b0);
                send_hit(5'd5, 2'd1, 6'd21, 7'd33, 31'd0, 1'b0);
                send_hit(5'd16, 2'd1, 6'd33, 7'd17, 31'h2AAA_AAAA, 1'b0);
                send_hit(5'd9, 2'd2, 6'd46, 7'd70, 31'h5555_5555, 1'b1);
            end
            for (int h = 0; h < HOT_SPOTS; h++) begin
                hot_ch[h] = 5'($urandom_range(0, NUM_CHANNELS - 1));
                hot_cp[h] = 2'($urandom_range(0, NUM_CHIPS - 1));
                hot_dc[h] = $urandom_range(0, NUM_DCOLS - 1);
            end
            next_ev = (phase == 4) ? EV_MAX - 5000 : $urandom_range(0, 1000);
            for (int i = 0; i < HITS_PER_PHASE; i++) begin
                send_random_hit();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
